>>> rtl/core/rthsv_pkg.sv
package rthsv_pkg;

   // Quotient bits produced by the divider pipeline, one per stage.
   localparam int unsigned DIV_STEPS = 17;

   // Hue units in one 60-degree sector (1/64 degree each).
   localparam logic [11:0] HUE_PER_SECTOR = 12'd3840;

   localparam logic [10:0] RED_WRAP_SECTORS = 11'd6;
   localparam logic [10:0] GREEN_SECTOR     = 11'd2;
   localparam logic [10:0] BLUE_SECTOR      = 11'd4;

   localparam logic [14:0] HUE_MAX = 15'd23039;
   localparam logic [16:0] SAT_ONE = 17'd65536;

   // One item on its way through the divider stages. Each bits field starts
   // as the low dividend bits and, shifted once per step, ends as the quotient.
   typedef struct packed {
      logic [7:0]  value;
      logic [7:0]  sat_divisor;
      logic [7:0]  hue_divisor;
      logic [7:0]  sat_rem;
      logic [7:0]  hue_rem;
      logic [16:0] sat_bits;
      logic [16:0] hue_bits;
   } rthsv_work_type;

endpackage

>>> rtl/core/rthsv_front.sv
module rthsv_front
   import rthsv_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic [23:0]    in_color,
   output logic           out_valid,
   input  logic           out_ready,
   output rthsv_work_type out_work
);

   logic [7:0]     red;
   logic [7:0]     green;
   logic [7:0]     blue;
   logic [7:0]     max_val;
   logic [7:0]     min_val;
   logic [7:0]     delta;
   logic [10:0]    numer;
   logic [22:0]    hue_dividend;
   logic           valid_ff;
   logic           valid_in;
   rthsv_work_type work_ff;
   rthsv_work_type work_in;

   assign red   = in_color[7:0];
   assign green = in_color[15:8];
   assign blue  = in_color[23:16];

   always_comb begin
      max_val = (red > green) ? red : green;
      if (blue > max_val) begin
         max_val = blue;
      end
      min_val = (red < green) ? red : green;
      if (blue < min_val) begin
         min_val = blue;
      end
      delta = max_val - min_val;

      // Ties go to red, then green. The sector offset keeps the numerator
      // non-negative, so the quotient is a plain unsigned one.
      if (red == max_val) begin
         if (green >= blue) begin
            numer = {3'd0, green - blue};
         end else begin
            numer = RED_WRAP_SECTORS * {3'd0, delta} - {3'd0, blue - green};
         end
      end else if (green == max_val) begin
         numer = GREEN_SECTOR * {3'd0, delta} + {3'd0, blue} - {3'd0, red};
      end else begin
         numer = BLUE_SECTOR * {3'd0, delta} + {3'd0, red} - {3'd0, green};
      end
      hue_dividend = {12'd0, numer} * {11'd0, HUE_PER_SECTOR};
   end

   always_comb begin
      work_in.value       = max_val;
      // A zero divisor only occurs with a zero dividend; dividing by one then
      // gives the required zero.
      work_in.sat_divisor = (max_val == 8'd0) ? 8'd1 : max_val;
      work_in.hue_divisor = (delta == 8'd0) ? 8'd1 : delta;
      work_in.sat_rem     = {1'b0, delta[7:1]};
      work_in.sat_bits    = {delta[0], 16'd0};
      work_in.hue_rem     = {2'd0, hue_dividend[22:17]};
      work_in.hue_bits    = hue_dividend[16:0];
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

>>> rtl/core/rthsv_div_stage.sv
module rthsv_div_stage
   import rthsv_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  rthsv_work_type in_work,
   output logic           out_valid,
   input  logic           out_ready,
   output rthsv_work_type out_work
);

   logic [8:0]     sat_trial;
   logic [8:0]     hue_trial;
   logic           sat_fits;
   logic           hue_fits;
   logic           valid_ff;
   logic           valid_in;
   rthsv_work_type work_ff;
   rthsv_work_type work_in;

   // One restoring step for each of the two quotients.
   always_comb begin
      sat_trial = {in_work.sat_rem, in_work.sat_bits[16]};
      hue_trial = {in_work.hue_rem, in_work.hue_bits[16]};
      sat_fits  = sat_trial >= {1'b0, in_work.sat_divisor};
      hue_fits  = hue_trial >= {1'b0, in_work.hue_divisor};

      work_in          = in_work;
      work_in.sat_bits = {in_work.sat_bits[15:0], sat_fits};
      work_in.hue_bits = {in_work.hue_bits[15:0], hue_fits};
      work_in.sat_rem  = sat_fits ? 8'(sat_trial - {1'b0, in_work.sat_divisor})
                                  : sat_trial[7:0];
      work_in.hue_rem  = hue_fits ? 8'(hue_trial - {1'b0, in_work.hue_divisor})
                                  : hue_trial[7:0];
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

>>> rtl/core/rgb_to_hsv_converter.sv
// RGB to HSV converter. Each req beat carries one 24-bit color (red low byte,
// then green, then blue); each rsp beat returns value (largest channel),
// saturation as Q1.16 with 65536 meaning 1.0, and hue in 1/64-degree units,
// 0..23039, with black and gray giving hue 0. A new color is taken every clock
// unless the pipeline is full and rsp is stalled. A registered front stage
// finds max, min and the hue sector, then a 17-stage restoring divider yields
// one bit of both quotients per stage. Results keep their input order. When
// rsp is stalled, empty stages still fill, so req keeps accepting until the
// pipeline is full.
module rgb_to_hsv_converter
   import rthsv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // pixel_color[23:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // hue[14:0], saturation[31:15], value[39:32]
);

   logic           stage_valid [0:DIV_STEPS];
   logic           stage_ready [0:DIV_STEPS];
   rthsv_work_type stage_work  [0:DIV_STEPS];

   rthsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_color  (req_tdata),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_work  (stage_work[0])
   );

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      rthsv_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_work   (stage_work[i]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_work  (stage_work[i+1])
      );
   end

   assign stage_ready[DIV_STEPS] = rsp_tready;
   assign rsp_tvalid = stage_valid[DIV_STEPS];
   // The hue quotient never exceeds 15 bits, so its top two bits are dropped.
   assign rsp_tdata  = {stage_work[DIV_STEPS].value,
                        stage_work[DIV_STEPS].sat_bits,
                        stage_work[DIV_STEPS].hue_bits[14:0]};

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[14:0] <= HUE_MAX)
      else $error("hue out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:15] <= SAT_ONE)
      else $error("saturation above one");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[39:32] == 8'd0 |->
         rsp_tdata[31:0] == 32'd0)
      else $error("black pixel with nonzero hue or saturation");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[31:15] == 17'd0 |-> rsp_tdata[14:0] == 15'd0)
      else $error("achromatic pixel with nonzero hue");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule

>>> tb/rgb_to_hsv_converter_tb.sv
`timescale 1ns / 100ps

module rgb_to_hsv_converter_tb;
   import rthsv_pkg::*;

   localparam int unsigned HUE_UNITS     = 3840;
   localparam int unsigned RANDOM_COLORS = 950;
   localparam int unsigned HOLD_AFTER    = 300;
   localparam int unsigned HOLD_CYCLES   = 200;
   localparam int unsigned DRAIN_CYCLES  = 40;
   localparam int unsigned CYCLE_LIMIT   = 200000;

   // Corner colors, packed as {blue, green, red}.
   localparam logic [23:0] CORNER_COLORS [20] = '{
      24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'h555555,
      24'h0000FF, 24'h00FF00, 24'hFF0000, 24'h0100FF, 24'h00FEFF,
      24'h00FFFF, 24'hFFFF00, 24'hFF00FF, 24'h000001, 24'h010000,
      24'hFEFFFF, 24'hFFFEFF, 24'hAAAAAA, 24'h5A3C1E, 24'h00FF01
   };

   typedef struct packed {
      logic [7:0]  value;
      logic [16:0] saturation;
      logic [14:0] hue;
   } hsv_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // pixel_color[23:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // hue[14:0], saturation[31:15], value[39:32]

   logic [23:0] pending_colors [$];
   hsv_type     expected_hsv [$];

   int unsigned send_gap = 0;
   int unsigned recv_gap = 0;
   bit          send_burst = 1'b0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;
   int unsigned results_seen = 0;
   int unsigned gray_colors = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   rgb_to_hsv_converter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic hsv_type hsv_of_color(logic [23:0] color);
      int unsigned red, green, blue, top, bottom, delta, numer;
      hsv_type     hsv;
      red    = 32'(color[7:0]);
      green  = 32'(color[15:8]);
      blue   = 32'(color[23:16]);
      top    = red;
      bottom = red;
      if (green > top) top = green;
      if (blue > top) top = blue;
      if (green < bottom) bottom = green;
      if (blue < bottom) bottom = blue;
      delta = top - bottom;
      hsv.value      = top[7:0];
      hsv.saturation = '0;
      hsv.hue        = '0;
      if (top != 0) hsv.saturation = 17'((delta << 16) / top);
      if (top != 0 && delta != 0) begin
         // Ties go to red first, then to green.
         if (red == top) begin
            if (green >= blue) numer = green - blue;
            else numer = 6 * delta - (blue - green);
         end else if (green == top) begin
            numer = 2 * delta + blue - red;
         end else begin
            numer = 4 * delta + red - green;
         end
         hsv.hue = 15'((numer * HUE_UNITS) / delta);
      end
      return hsv;
   endfunction

   // Mostly full-range colors, with a share of grays, channel ties at the
   // maximum and nearly equal channels where delta is tiny.
   function automatic logic [23:0] random_color();
      logic [7:0]  base, top, low;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      base = 8'($urandom);
      top  = 8'($urandom);
      low  = 8'($urandom_range(0, 32'(top)));
      if (pick == 0) return {base, base, base};
      if (pick == 1) begin
         case ($urandom_range(0, 2))
            0: return {low, top, top};
            1: return {top, low, top};
            default: return {top, top, low};
         endcase
      end
      if (pick == 2) begin
         return {base ^ 8'($urandom_range(0, 3)), base ^ 8'($urandom_range(0, 3)),
                 base ^ 8'($urandom_range(0, 3))};
      end
      return 24'($urandom);
   endfunction

   // Driver: offers one color per beat, with a random gap after each.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_hsv.push_back(hsv_of_color(req_tdata));
            if (req_tdata[7:0] == req_tdata[15:8] && req_tdata[7:0] == req_tdata[23:16])
               gray_colors++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_colors.size() != 0) begin
               req_tdata  <= pending_colors.pop_front();
               req_tvalid <= 1'b1;
               if ($urandom_range(0, 40) == 0) send_burst = ~send_burst;
               send_gap = send_burst ? 0 : $urandom_range(0, 4);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result beat against the oldest prediction.
   always @(posedge clock) begin
      hsv_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            results_seen <= results_seen + 1;
            if (expected_hsv.size() == 0) begin
               $display("%0t: unexpected result beat, actual %h", $time, rsp_tdata);
               error_count++;
            end else begin
               want = expected_hsv.pop_front();
               if (got.hue != want.hue) begin
                  $display("%0t: hue expected %0d actual %0d", $time, want.hue, got.hue);
                  error_count++;
               end
               if (got.saturation != want.saturation) begin
                  $display("%0t: saturation expected %0d actual %0d", $time,
                           want.saturation, got.saturation);
                  error_count++;
               end
               if (got.value != want.value) begin
                  $display("%0t: value expected %0d actual %0d", $time,
                           want.value, got.value);
                  error_count++;
               end
            end
            recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // One long hold-off on the result side so the pipeline fills and the
   // input side has to stall.
   always @(posedge clock) begin
      if (!reset) begin
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_hsv.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      foreach (CORNER_COLORS[i]) pending_colors.push_back(CORNER_COLORS[i]);
      for (int i = 0; i < RANDOM_COLORS; i++) pending_colors.push_back(random_color());
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (pending_colors.size() != 0 || req_tvalid || expected_hsv.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      // Every accepted color must have produced its result by now.
      if (expected_hsv.size() != 0) begin
         $display("%0t: results expected %0d actual 0 (missing)", $time,
                  expected_hsv.size());
         error_count++;
      end
      $display("Converted %0d colors (%0d gray or black), with random gaps on both sides",
               results_seen, gray_colors);
      $display("and one %0d-cycle result stall; %0d mismatches.", HOLD_CYCLES, error_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
